FILE: rtl/bmf_pkg.sv
// Package for the binary morphology filter: geometry constants, codes and the
// structs passed between the control, line store and window modules.
// No dependencies.
package bmf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int KERNEL_MAX = 7;
   localparam int LANES      = 8;
   localparam int LANE_W     = $clog2(LANES);
   localparam int MEM_DEPTH  = MAX_WIDTH / LANES + 2;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);
   localparam int WORD_W     = LANES * KERNEL_MAX;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W      = 11;
   localparam int KDIM_W     = 3;
   localparam int MASK_W     = KERNEL_MAX * KERNEL_MAX;
   localparam int RMOD_W     = $clog2(KERNEL_MAX);
   localparam int CNT_W      = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 49;
   localparam int PIX_W      = 8;

   localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;

   // operation modes
   localparam logic [1:0] MODE_BYPASS = 2'd0;
   localparam logic [1:0] MODE_ERODE  = 2'd1;
   localparam logic [1:0] MODE_DILATE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OP_MODE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_COLS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_MASK  = 3'd5;

   // request kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // window geometry of one output item, resolved at accept time
   typedef struct packed {
      logic                                 bypass;
      logic                                 erode;
      logic                                 last;
      logic [PIX_W-1:0]                     pixel;
      logic [KERNEL_MAX-1:0]                row_ok;
      logic [KERNEL_MAX-1:0][RMOD_W-1:0]    row_mod;
      logic [KERNEL_MAX-1:0]                col_ok;
      logic [LANE_W-1:0]                    lane_off;
      logic [MASK_W-1:0]                    used;
      logic [KERNEL_MAX-1:0]                patch_col;
      logic [RMOD_W-1:0]                    patch_row;
      logic                                 patch_val;
   } win_type;

   // line store access of one accepted item
   typedef struct packed {
      logic               wr_en;
      logic [MEM_AW-1:0]  wr_addr;
      logic [LANE_W-1:0]  wr_lane;
      logic [RMOD_W-1:0]  wr_row;
      logic               wr_bit;
      logic               rd_en;
      logic [MEM_AW-1:0]  rd_addr;
   } mem_req_type;

endpackage

FILE: rtl/bmf_req_if.sv
// Request channel of the morphology filter: valid/ready plus one pixel item.
// Depends on bmf_pkg.
interface bmf_req_if import bmf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [PIX_W-1:0] pixel_value;

   modport source (output valid, output req_type, output pixel_value, input ready);
   modport sink   (input valid, input req_type, input pixel_value, output ready);
endinterface

FILE: rtl/bmf_rsp_if.sv
// Result channel of the morphology filter: valid/ready plus one output item.
// Depends on bmf_pkg.
interface bmf_rsp_if import bmf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] result_value;
   logic             frame_last;

   modport source (output valid, output result_value, output frame_last, input ready);
   modport sink   (input valid, input result_value, input frame_last, output ready);
endinterface

FILE: rtl/bmf_line_store.sv
// Line store: one bit per pixel for KERNEL_MAX rows, eight columns to a word,
// bit-write port and two registered read ports. Depends on bmf_pkg.
module bmf_line_store import bmf_pkg::*; (
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [WORD_W-1:0] rd_lo,
   output logic [WORD_W-1:0] rd_hi
);

   logic [WORD_W-1:0] mem [MEM_DEPTH];
   logic [WORD_W-1:0] rd_lo_ff;
   logic [WORD_W-1:0] rd_hi_ff;
   logic [BIT_W-1:0]  bit_idx;
   logic [MEM_AW-1:0] rd_addr_hi;

   assign bit_idx    = BIT_W'(mem_req.wr_lane) * BIT_W'(KERNEL_MAX) + BIT_W'(mem_req.wr_row);
   assign rd_addr_hi = mem_req.rd_addr + MEM_AW'(1);

   // write one pixel bit, read two neighboring words
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr][bit_idx] <= mem_req.wr_bit;
      end
      if (mem_req.rd_en) begin
         rd_lo_ff <= mem[mem_req.rd_addr];
         rd_hi_ff <= mem[rd_addr_hi];
      end
   end

   assign rd_lo = rd_lo_ff;
   assign rd_hi = rd_hi_ff;

endmodule

FILE: rtl/bmf_ctrl.sv
// Control of the morphology filter: configuration registers, frame position
// counters, line store addressing and window geometry. Depends on bmf_pkg.
module bmf_ctrl import bmf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_fire,
   input  logic                  req_type,
   input  logic [PIX_W-1:0]      pixel_value,
   output logic                  emit_fire,
   output win_type               win,
   output mem_req_type           mem_req
);

   logic [DIM_W-1:0]  frame_width_ff, frame_height_ff;
   logic [1:0]        mode_ff;
   logic [KDIM_W-1:0] kcols_ff, krows_ff;
   logic [MASK_W-1:0] kmask_ff;

   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [DIM_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RMOD_W-1:0] in_rmod_ff, in_rmod_in, out_rmod_ff, out_rmod_in;
   logic [CNT_W-1:0]  recv_ff, recv_in;

   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [KDIM_W-1:0] kc_eff, kr_eff, cx, cy, lagc, lagr;
   logic [CNT_W-1:0]  lag, recv_nx;
   logic              morph, erode, flush, in_open, pixel_ok, emit, last, cfg_hit;
   logic [DIM_W-1:0]  in_col1, out_col1, wcc, cc;

   function automatic logic [RMOD_W-1:0] wrap_row(input logic [RMOD_W+1:0] v);
      logic [RMOD_W+1:0] r;
      if (v >= (RMOD_W+2)'(2 * KERNEL_MAX)) r = v - (RMOD_W+2)'(2 * KERNEL_MAX);
      else if (v >= (RMOD_W+2)'(KERNEL_MAX)) r = v - (RMOD_W+2)'(KERNEL_MAX);
      else r = v;
      return r[RMOD_W-1:0];
   endfunction

   // effective geometry
   always_comb begin
      if (frame_width_ff == '0) w_eff = DIM_W'(1);
      else if (frame_width_ff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      else w_eff = frame_width_ff;
      h_eff  = (frame_height_ff == '0) ? DIM_W'(1) : frame_height_ff;
      kc_eff = (kcols_ff == '0) ? KDIM_W'(1) :
               (kcols_ff > KDIM_W'(KERNEL_MAX)) ? KDIM_W'(KERNEL_MAX) : kcols_ff;
      kr_eff = (krows_ff == '0) ? KDIM_W'(1) :
               (krows_ff > KDIM_W'(KERNEL_MAX)) ? KDIM_W'(KERNEL_MAX) : krows_ff;
      cx   = kc_eff >> 1;
      cy   = kr_eff >> 1;
      lagc = kc_eff - KDIM_W'(1) - cx;
      lagr = kr_eff - KDIM_W'(1) - cy;
      lag  = CNT_W'(lagr) * CNT_W'(w_eff) + CNT_W'(lagc);
   end

   // decide what the item does
   always_comb begin
      morph    = (mode_ff == MODE_ERODE) || (mode_ff == MODE_DILATE);
      erode    = (mode_ff == MODE_ERODE);
      flush    = (req_type == REQ_FLUSH);
      in_open  = (in_row_ff < h_eff);
      recv_nx  = recv_ff + CNT_W'(1);
      pixel_ok = !flush && (!morph || in_open);
      if (!morph) emit = !flush;
      else if (flush) emit = !in_open;
      else emit = in_open && (recv_nx > lag);
      last = (out_row_ff == h_eff - DIM_W'(1)) &&
             ({1'b0, out_col_ff} == w_eff - DIM_W'(1));
   end

   assign emit_fire = req_fire && emit;

   // advance counters
   always_comb begin
      in_col1  = {1'b0, in_col_ff} + DIM_W'(1);
      out_col1 = {1'b0, out_col_ff} + DIM_W'(1);
      in_col_in = in_col_ff; in_row_in = in_row_ff; in_rmod_in = in_rmod_ff;
      recv_in = recv_ff;
      out_col_in = out_col_ff; out_row_in = out_row_ff; out_rmod_in = out_rmod_ff;
      if (req_fire && pixel_ok) begin
         recv_in = recv_nx;
         if (in_col1 >= w_eff) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + DIM_W'(1);
            in_rmod_in = (in_rmod_ff == RMOD_W'(KERNEL_MAX - 1)) ? '0
                       : in_rmod_ff + RMOD_W'(1);
         end else begin
            in_col_in = in_col1[COL_W-1:0];
         end
      end
      if (emit_fire) begin
         if (out_col1 >= w_eff) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + DIM_W'(1);
            out_rmod_in = (out_rmod_ff == RMOD_W'(KERNEL_MAX - 1)) ? '0
                        : out_rmod_ff + RMOD_W'(1);
         end else begin
            out_col_in = out_col1[COL_W-1:0];
         end
      end
      // restart the frame after its last output
      if (emit_fire && last) begin
         in_col_in = '0; in_row_in = '0; in_rmod_in = '0; recv_in = '0;
         out_col_in = '0; out_row_in = '0; out_rmod_in = '0;
      end
   end

   // configuration decode
   always_comb begin
      unique case (csr_index)
         REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_OP_MODE,
         REG_KERNEL_COLS, REG_KERNEL_ROWS, REG_KERNEL_MASK: cfg_hit = 1'b1;
         default: cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(1024);
         frame_height_ff <= DIM_W'(1024);
         mode_ff         <= MODE_ERODE;
         kcols_ff        <= KDIM_W'(3);
         krows_ff        <= KDIM_W'(3);
         kmask_ff        <= MASK_W'(115591);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[DIM_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_write_data[DIM_W-1:0];
            REG_OP_MODE:      mode_ff         <= csr_write_data[1:0];
            REG_KERNEL_COLS:  kcols_ff        <= csr_write_data[KDIM_W-1:0];
            REG_KERNEL_ROWS:  krows_ff        <= csr_write_data[KDIM_W-1:0];
            REG_KERNEL_MASK:  kmask_ff        <= csr_write_data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_write_enable && cfg_hit)) begin
         in_col_ff <= '0; in_row_ff <= '0; in_rmod_ff <= '0; recv_ff <= '0;
         out_col_ff <= '0; out_row_ff <= '0; out_rmod_ff <= '0;
      end else begin
         in_col_ff <= in_col_in; in_row_ff <= in_row_in; in_rmod_ff <= in_rmod_in;
         recv_ff <= recv_in;
         out_col_ff <= out_col_in; out_row_ff <= out_row_in; out_rmod_ff <= out_rmod_in;
      end
   end

   // line store access: write the new bit, read the words under the window
   always_comb begin
      wcc = {1'b0, in_col_ff} + DIM_W'(LANES);
      cc  = {1'b0, out_col_ff} + DIM_W'(LANES) - DIM_W'(cx);
      mem_req.wr_en   = req_fire && morph && !flush && in_open;
      mem_req.wr_addr = MEM_AW'(wcc >> LANE_W);
      mem_req.wr_lane = wcc[LANE_W-1:0];
      mem_req.wr_row  = in_rmod_ff;
      mem_req.wr_bit  = (pixel_value != '0);
      mem_req.rd_en   = emit_fire;
      mem_req.rd_addr = MEM_AW'(cc >> LANE_W);
   end

   // window geometry around the output position
   always_comb begin
      logic [DIM_W:0] rr;
      logic [DIM_W:0] cm;
      win.bypass    = !morph;
      win.erode     = erode;
      win.last      = last;
      win.pixel     = pixel_value;
      win.lane_off  = cc[LANE_W-1:0];
      win.patch_row = in_rmod_ff;
      win.patch_val = (pixel_value != '0);
      for (int n = 0; n < KERNEL_MAX; n++) begin
         rr = {1'b0, out_row_ff} + (DIM_W+1)'(n);
         win.row_ok[n] = (rr >= (DIM_W+1)'(cy)) &&
                         (rr - (DIM_W+1)'(cy) < {1'b0, h_eff});
         win.row_mod[n] = wrap_row((RMOD_W+2)'(out_rmod_ff) + (RMOD_W+2)'(n) +
                                   (RMOD_W+2)'(KERNEL_MAX) - (RMOD_W+2)'(cy));
      end
      for (int m = 0; m < KERNEL_MAX; m++) begin
         cm = (DIM_W+1)'(out_col_ff) + (DIM_W+1)'(m);
         win.col_ok[m] = (cm >= (DIM_W+1)'(cx)) &&
                         (cm - (DIM_W+1)'(cx) < {1'b0, w_eff});
         win.patch_col[m] = mem_req.wr_en && (cm >= (DIM_W+1)'(cx)) &&
                            (cm - (DIM_W+1)'(cx) == (DIM_W+1)'(in_col_ff));
      end
      for (int n = 0; n < KERNEL_MAX; n++) begin
         for (int m = 0; m < KERNEL_MAX; m++) begin
            win.used[n * KERNEL_MAX + m] = kmask_ff[n * KERNEL_MAX + m] &&
               (KDIM_W'(n) < kr_eff) && (KDIM_W'(m) < kc_eff);
         end
      end
   end

endmodule

FILE: rtl/bmf_window.sv
// Window stage and output register: picks the masked window bits out of the
// line store words, reduces them and holds the result item. Depends on bmf_pkg.
module bmf_window import bmf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  win_type           win,
   input  logic [WORD_W-1:0] rd_lo,
   input  logic [WORD_W-1:0] rd_hi,
   output logic              in_ready,
   bmf_rsp_if.source         rsp_chan
);

   logic             s1_valid_ff, s1_valid_in;
   win_type          s1_ff;
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_value_ff, out_value_in;
   logic             out_last_ff;
   logic             out_free, s1_move;

   logic [2*LANES-1:0][KERNEL_MAX-1:0] lane_bits;
   logic [MASK_W-1:0]                  hit;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign in_ready = !s1_valid_ff || out_free;

   assign s1_valid_in  = load || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_chan.ready);
   assign lane_bits    = {rd_hi, rd_lo};

   // gather window bits, patching the bit written in the same cycle as the read
   always_comb begin
      logic [LANE_W:0] li;
      logic            bit_set;
      for (int n = 0; n < KERNEL_MAX; n++) begin
         for (int m = 0; m < KERNEL_MAX; m++) begin
            li = {1'b0, s1_ff.lane_off} + (LANE_W+1)'(m);
            if (s1_ff.patch_col[m] && (s1_ff.row_mod[n] == s1_ff.patch_row)) begin
               bit_set = s1_ff.patch_val;
            end else begin
               bit_set = lane_bits[li][s1_ff.row_mod[n]];
            end
            hit[n * KERNEL_MAX + m] = (s1_ff.row_ok[n] && s1_ff.col_ok[m]) ? bit_set
                                      : s1_ff.erode;
         end
      end
   end

   // reduce over the element
   always_comb begin
      if (s1_ff.bypass) begin
         out_value_in = s1_ff.pixel;
      end else if (s1_ff.erode) begin
         out_value_in = (&(~s1_ff.used | hit)) ? FG_VALUE : '0;
      end else begin
         out_value_in = (|(s1_ff.used & hit)) ? FG_VALUE : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold payloads
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= win;
      end
      if (s1_move) begin
         out_value_ff <= out_value_in;
         out_last_ff  <= s1_ff.last;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_value = out_value_ff;
   assign rsp_chan.frame_last   = out_last_ff;

endmodule

FILE: rtl/binary_morphology_filter.sv
// Binary erosion/dilation on a raster pixel stream with a structuring element
// of up to 7x7. The block takes one item per clock; a result passes the window
// stage and output registers once its item is accepted, and the whole path is a
// single line store with one bit-write port and two registered reads
// per cycle, so back-to-back items never stall except when the output is held.
// Results trail the pixels by (rows-1-rows/2) lines plus (cols-1-cols/2) pixels;
// send that many flush items after a frame to drain it. The line store needs no
// clearing pass after reset. A configuration write restarts the frame.
module binary_morphology_filter import bmf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   bmf_req_if.sink               req_chan,
   bmf_rsp_if.source             rsp_chan
);

   logic              in_ready, req_fire, emit_fire;
   win_type           win;
   mem_req_type       mem_req;
   logic [WORD_W-1:0] rd_lo, rd_hi;

   assign req_chan.ready = in_ready;
   assign req_fire       = req_chan.valid && in_ready;

   bmf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_fire         (req_fire),
      .req_type         (req_chan.req_type),
      .pixel_value      (req_chan.pixel_value),
      .emit_fire        (emit_fire),
      .win              (win),
      .mem_req          (mem_req)
   );

   bmf_line_store u_line_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_lo   (rd_lo),
      .rd_hi   (rd_hi)
   );

   bmf_window u_window (
      .clock    (clock),
      .reset    (reset),
      .load     (emit_fire),
      .win      (win),
      .rd_lo    (rd_lo),
      .rd_hi    (rd_hi),
      .in_ready (in_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for binary_morphology_filter: erosion, dilation and
// bypass over random frames, checked against an in-bench pixel predictor.
// Depends on bmf_pkg, bmf_req_if and bmf_rsp_if from the RTL.
module tb_top;
   import bmf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam int RANDOM_ITEMS = 200;
   localparam int CYCLE_LIMIT  = 2_000_000;

   typedef struct {
      logic             kind;
      logic [PIX_W-1:0] pix;
   } pixel_item_t;

   typedef struct {
      logic [PIX_W-1:0] value;
      logic             last;
   } out_pixel_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   bmf_req_if req_bus ();
   bmf_rsp_if rsp_bus ();

   binary_morphology_filter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state: shadow registers, bit store and position counters
   logic [DIM_W-1:0]  shadow_width, shadow_height;
   logic [1:0]        shadow_mode;
   logic [KDIM_W-1:0] shadow_kcols, shadow_krows;
   logic [MASK_W-1:0] shadow_mask;
   bit                fg_bits [KERNEL_MAX*MAX_WIDTH];
   int                in_col, in_row, out_col, out_row;

   pixel_item_t pending_pixels[$];
   out_pixel_t  expected_pixels[$];
   int          pushed_cnt, accepted_cnt, random_items;
   int          err_cnt;
   bit          gaps_on;
   longint      cycle_cnt;

   function automatic int eff_width();
      if (shadow_width == 0) return 1;
      if (shadow_width > MAX_WIDTH) return MAX_WIDTH;
      return shadow_width;
   endfunction

   function automatic int eff_height();
      return (shadow_height == 0) ? 1 : shadow_height;
   endfunction

   function automatic int eff_ksize(logic [KDIM_W-1:0] k);
      if (k == 0) return 1;
      if (k > KERNEL_MAX) return KERNEL_MAX;
      return k;
   endfunction

   function automatic int drain_lag();
      int kr, kc;
      kr = eff_ksize(shadow_krows);
      kc = eff_ksize(shadow_kcols);
      return (kr - 1 - kr / 2) * eff_width() + (kc - 1 - kc / 2);
   endfunction

   function automatic logic [PIX_W-1:0] window_value(bit erode);
      int w, h, kr, kc, cy, cx, r, c;
      bit hit;
      w = eff_width();
      h = eff_height();
      kr = eff_ksize(shadow_krows);
      kc = eff_ksize(shadow_kcols);
      cy = kr / 2;
      cx = kc / 2;
      for (int n = 0; n < kr; n++) begin
         for (int m = 0; m < kc; m++) begin
            if (!shadow_mask[n*KERNEL_MAX+m]) continue;
            r = out_row + n - cy;
            c = out_col + m - cx;
            if (r < 0 || c < 0 || r >= h || c >= w) hit = erode;
            else hit = fg_bits[(r % KERNEL_MAX) * MAX_WIDTH + c];
            if (erode && !hit) return 8'd0;
            if (!erode && hit) return FG_VALUE;
         end
      end
      return erode ? FG_VALUE : 8'd0;
   endfunction

   // queue one output pixel and step the output position
   function automatic void emit_pixel(logic [PIX_W-1:0] value);
      out_pixel_t o;
      int w, h;
      w = eff_width();
      h = eff_height();
      o.value = value;
      o.last = (out_row == h - 1) && (out_col == w - 1);
      expected_pixels.insert(expected_pixels.size(), o);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (o.last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
   endfunction

   function automatic void morph_predict(pixel_item_t it);
      int w, h, received;
      bit erode, morph;
      w = eff_width();
      h = eff_height();
      erode = (shadow_mode == MODE_ERODE);
      morph = erode || (shadow_mode == MODE_DILATE);
      if (!morph) begin
         if (it.kind == REQ_FLUSH) return;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         emit_pixel(it.pix);
         return;
      end
      if (it.kind == REQ_FLUSH) begin
         if (in_row < h) return;
         emit_pixel(window_value(erode));
         return;
      end
      // drop pixels while the frame is draining
      if (in_row >= h) return;
      fg_bits[(in_row % KERNEL_MAX) * MAX_WIDTH + in_col] = (it.pix != 0);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      received = in_row * w + in_col;
      if (received <= drain_lag()) return;
      emit_pixel(window_value(erode));
   endfunction

   // driver: present items from the pending queue, with idle bursts
   logic        next_valid;
   pixel_item_t cur_item;
   int          send_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         next_valid = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            morph_predict(cur_item);
            accepted_cnt++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (gaps_on && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(0, 13);
            end else if (pending_pixels.size() > 0) begin
               cur_item = pending_pixels.pop_front();
               next_valid = 1'b1;
            end
         end
         req_bus.valid <= next_valid;
         req_bus.req_type <= cur_item.kind;
         req_bus.pixel_value <= cur_item.pix;
      end
   end

   // receiver stalls in random bursts
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   out_pixel_t want;
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result value %0d last %0d",
                   rsp_bus.result_value, rsp_bus.frame_last);
            err_cnt++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_bus.result_value !== want.value) begin
               $error("result_value expected %0d actual %0d", want.value,
                      rsp_bus.result_value);
               err_cnt++;
            end
            if (rsp_bus.frame_last !== want.last) begin
               $error("frame_last expected %0d actual %0d", want.last,
                      rsp_bus.frame_last);
               err_cnt++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_item(logic kind, logic [PIX_W-1:0] pix);
      pixel_item_t it;
      it.kind = kind;
      it.pix = pix;
      pending_pixels.insert(pending_pixels.size(), it);
      pushed_cnt++;
   endtask

   // write one register; the predictor follows at once since the block is idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         REG_FRAME_WIDTH:  shadow_width = data[DIM_W-1:0];
         REG_FRAME_HEIGHT: shadow_height = data[DIM_W-1:0];
         REG_OP_MODE:      shadow_mode = data[1:0];
         REG_KERNEL_COLS:  shadow_kcols = data[KDIM_W-1:0];
         REG_KERNEL_ROWS:  shadow_krows = data[KDIM_W-1:0];
         REG_KERNEL_MASK:  shadow_mask = data[MASK_W-1:0];
         default: ;
      endcase
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(int w, int h, logic [1:0] mode, int kc, int kr,
                            logic [MASK_W-1:0] mask);
      write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(h));
      write_reg(REG_OP_MODE, CSR_DATA_W'(mode));
      write_reg(REG_KERNEL_COLS, CSR_DATA_W'(kc));
      write_reg(REG_KERNEL_ROWS, CSR_DATA_W'(kr));
      write_reg(REG_KERNEL_MASK, CSR_DATA_W'(mask));
   endtask

   // hold until every item is taken and every result has come, plus latency
   task automatic wait_idle();
      do @(posedge clock); while (accepted_cnt != pushed_cnt);
      while (expected_pixels.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel(int density);
      if ($urandom_range(0, 99) >= density) return 8'd0;
      if ($urandom_range(0, 3) == 0) return FG_VALUE;
      return PIX_W'($urandom_range(1, 255));
   endfunction

   function automatic logic [MASK_W-1:0] rand_mask();
      logic [MASK_W-1:0] m;
      case ($urandom_range(0, 5))
         0: m = '0;
         1: m = '1;
         2: m = MASK_W'({$urandom, $urandom} & {$urandom, $urandom} &
                        {$urandom, $urandom});
         default: m = MASK_W'({$urandom, $urandom});
      endcase
      return m;
   endfunction

   // one frame: pixels with some noise, then the drain flushes
   task automatic run_frame(int w, int h, logic [1:0] mode, int kc, int kr,
                            logic [MASK_W-1:0] mask, bit pause_mid, bit partial);
      int npx, nflush, density, start;
      start = pushed_cnt;
      configure(w, h, mode, kc, kr, mask);
      density = $urandom_range(0, 100);
      npx = eff_width() * eff_height();
      if (partial) npx = $urandom_range(1, npx);
      for (int i = 0; i < npx; i++) begin
         if ($urandom_range(0, 15) == 0) push_item(REQ_FLUSH, rand_pixel(50));
         push_item(REQ_PIXEL, rand_pixel(density));
         if (pause_mid && i == npx / 2) wait_idle();
      end
      nflush = drain_lag() < npx ? drain_lag() : npx;
      if (partial) nflush = $urandom_range(0, nflush);
      for (int i = 0; i < nflush; i++) begin
         if ($urandom_range(0, 15) == 0) push_item(REQ_PIXEL, rand_pixel(50));
         push_item(REQ_FLUSH, PIX_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) push_item(REQ_FLUSH, PIX_W'($urandom_range(0, 255)));
      wait_idle();
      random_items += pushed_cnt - start;
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_PIXEL;
      req_bus.pixel_value = '0;
      rsp_bus.ready = 1'b0;
      cur_item.kind = REQ_PIXEL;
      cur_item.pix = '0;
      shadow_width = 11'd1024;
      shadow_height = 11'd1024;
      shadow_mode = MODE_ERODE;
      shadow_kcols = 3'd3;
      shadow_krows = 3'd3;
      shadow_mask = 49'd115591;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      gaps_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: bypass with field extremes and an ignored flush
      configure(3, 2, MODE_BYPASS, 3, 3, 49'd115591);
      push_item(REQ_PIXEL, 8'd0);
      push_item(REQ_FLUSH, 8'd255);
      push_item(REQ_PIXEL, 8'd255);
      push_item(REQ_PIXEL, 8'd1);
      push_item(REQ_PIXEL, 8'd128);
      push_item(REQ_PIXEL, 8'd127);
      push_item(REQ_PIXEL, 8'd85);
      wait_idle();
      // directed: erode a 3x2 frame, early flush, drain, flush with nothing pending
      write_reg(REG_OP_MODE, CSR_DATA_W'(MODE_ERODE));
      push_item(REQ_PIXEL, 8'd255);
      push_item(REQ_FLUSH, 8'd0);
      push_item(REQ_PIXEL, 8'd1);
      push_item(REQ_PIXEL, 8'd170);
      push_item(REQ_PIXEL, 8'd0);
      push_item(REQ_PIXEL, 8'd255);
      push_item(REQ_PIXEL, 8'd255);
      push_item(REQ_FLUSH, 8'd0);
      push_item(REQ_PIXEL, 8'd0);
      push_item(REQ_FLUSH, 8'd0);
      push_item(REQ_FLUSH, 8'd0);
      push_item(REQ_FLUSH, 8'd0);
      push_item(REQ_FLUSH, 8'd0);
      wait_idle();

      // random frames, mostly small
      while (random_items < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         run_frame($urandom_range(0, 12), $urandom_range(0, 9),
                   2'($urandom_range(0, 3)),
                   $urandom_range(0, 7), $urandom_range(0, 7), rand_mask(),
                   $urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0);
      end

      // geometry extremes, the mid-frame pause, then a stretch with no idling
      gaps_on = 1'b1;
      run_frame(7, 6, MODE_DILATE, 7, 7, '1, 1'b1, 1'b0);
      run_frame(2047, 1, MODE_ERODE, 7, 2, rand_mask(), 1'b0, 1'b0);
      run_frame(1, 40, MODE_ERODE, 1, 7, rand_mask(), 1'b0, 1'b0);
      gaps_on = 1'b0;
      run_frame(0, 0, MODE_DILATE, 0, 0, '1, 1'b0, 1'b0);
      run_frame(9, 7, MODE_ERODE, 7, 7, '1, 1'b0, 1'b0);
      run_frame(6, 5, MODE_RESERVED, 2, 2, '0, 1'b0, 1'b0);
      run_frame(8, 8, MODE_DILATE, 4, 6, rand_mask(), 1'b0, 1'b0);

      repeat (20) @(posedge clock);
      if (err_cnt == 0 && expected_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/bmf_pkg.sv
rtl/bmf_req_if.sv
rtl/bmf_rsp_if.sv
rtl/bmf_line_store.sv
rtl/bmf_ctrl.sv
rtl/bmf_window.sv
rtl/binary_morphology_filter.sv
tb/tb_top.sv
